FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the frame selector checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define KMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define KMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Types, widths and constants shared by the keyframe motion selector.
// ----------------------------------------------------------------------------
`default_nettype none

package kms_pkg;

    localparam int MAX_FRAMES  = 256;
    localparam int IDX_W       = $clog2(MAX_FRAMES);
    localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
    localparam int MEAN_W      = 16;
    localparam int RATIO_W     = 17;
    localparam int MINRUN_W    = 9;
    localparam int RUN_W       = (CNT_W > MINRUN_W) ? CNT_W : MINRUN_W;
    localparam int OUT_IDX_W   = 8;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [RATIO_W-1:0]  RATIO_MAX      = 17'd65536;
    localparam logic [MEAN_W-1:0]   DARK_RESET     = 16'd2560;
    localparam logic [RATIO_W-1:0]  MOTION_RESET   = 17'd3277;
    localparam logic [RATIO_W-1:0]  STABLE_RESET   = 17'd655;
    localparam logic [MINRUN_W-1:0] MINRUN_RESET   = 9'd3;

    typedef enum logic [1:0] {
        REG_DARK   = 2'd0,
        REG_MOTION = 2'd1,
        REG_STABLE = 2'd2,
        REG_MINRUN = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic               usable;
        logic [RATIO_W-1:0] ratio;
        logic               last;
    } t_entry;

    typedef struct packed {
        logic               usable;
        logic [RATIO_W-1:0] ratio;
    } t_frame;

    typedef struct packed {
        logic [RATIO_W-1:0]  motion_thr;
        logic [RATIO_W-1:0]  stable_thr;
        logic [MINRUN_W-1:0] min_run;
    } t_scan_cfg;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] before_frame;
        logic [OUT_IDX_W-1:0] after_frame;
        logic [RATIO_W-1:0]   peak_ratio;
        logic                 overflow;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/kms_front.sv
// ----------------------------------------------------------------------------
// kms_front
// Accepts frame summaries, classifies usability and saturates the ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [kms_pkg::MEAN_W-1:0]   i_frame_mean,
    input  wire logic                         i_frame_empty,
    input  wire logic [kms_pkg::RATIO_W-1:0]  i_change_to_next,
    input  wire logic                         i_last_frame,
    input  wire logic [kms_pkg::MEAN_W-1:0]   i_dark_thr,
    output logic                              o_q_valid,
    input  wire logic                         i_q_ready,
    output kms_pkg::t_entry                   o_q_entry
);

    logic            r_valid;
    kms_pkg::t_entry r_entry;
    kms_pkg::t_entry n_entry;
    logic            accept;

    assign o_in_ready = !r_valid || i_q_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_entry.usable = !i_frame_empty && (i_frame_mean >= i_dark_thr);
        n_entry.ratio  = (i_change_to_next > kms_pkg::RATIO_MAX) ?
                         kms_pkg::RATIO_MAX : i_change_to_next;
        n_entry.last   = i_last_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_entry = r_entry;

endmodule

`default_nettype wire

FILE: sv/kms_queue.sv
// ----------------------------------------------------------------------------
// kms_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    output logic                 o_push_ready,
    input  wire kms_pkg::t_entry i_push_data,
    output logic                 o_pop_valid,
    input  wire logic            i_pop_ready,
    output kms_pkg::t_entry      o_pop_data
);

    kms_pkg::t_entry               r_slots [kms_pkg::QUEUE_DEPTH];
    logic [kms_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [kms_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [kms_pkg::QPTR_W:0]      r_fill;
    logic                          push;
    logic                          pop;

    assign o_push_ready = (r_fill != (kms_pkg::QPTR_W+1)'(kms_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/kms_back.sv
// ----------------------------------------------------------------------------
// kms_back
// Stores frames, scans them after the last one and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    output logic                    o_q_ready,
    input  wire kms_pkg::t_entry    i_q_entry,
    input  wire kms_pkg::t_scan_cfg i_cfg,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output kms_pkg::t_result        o_result
);

    localparam int IW = kms_pkg::IDX_W;
    localparam int CW = kms_pkg::CNT_W;
    localparam int RW = kms_pkg::RATIO_W;
    localparam int LW = kms_pkg::RUN_W;

    kms_pkg::t_state  r_state;
    kms_pkg::t_state  n_state;

    kms_pkg::t_frame  r_mem [kms_pkg::MAX_FRAMES];
    kms_pkg::t_frame  r_rd_data;

    logic [CW-1:0]    r_count;
    logic [RW-1:0]    r_peak;
    logic [RW-1:0]    r_last_ratio;
    logic             r_dropped;

    logic [CW-1:0]    r_issue;
    logic             r_rd_valid;
    logic [IW-1:0]    r_rd_idx;
    logic             r_prev_u;
    logic [RW-1:0]    r_prev_ratio;
    logic             r_any_u;
    logic [IW-1:0]    r_first_u;
    logic [IW-1:0]    r_last_u;
    logic             r_any_m;
    logic [IW-1:0]    r_fm;
    logic             r_best_valid;
    logic [IW-1:0]    r_best;
    logic [LW-1:0]    r_run_len;

    logic             r_out_valid;
    kms_pkg::t_result r_res;

    logic             pop;
    logic             store;
    logic             issue;
    logic             scan_done;
    logic             out_free;
    logic             finish;
    logic             motion_t;
    logic             cont;
    logic [LW-1:0]    run_new;
    logic             qualify;
    logic [IW-1:0]    n_bef;
    logic [IW-1:0]    n_aft;
    logic [IW-1:0]    aft_sel;
    kms_pkg::t_result n_res;

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_q_ready = (r_state == kms_pkg::ST_LOAD);
    assign pop       = o_q_ready && i_q_valid;
    assign store     = pop && (r_count < CW'(kms_pkg::MAX_FRAMES));
    assign issue     = (r_state == kms_pkg::ST_SCAN) && (r_issue < r_count);
    assign scan_done = (r_state == kms_pkg::ST_SCAN) && !issue && !r_rd_valid;
    assign finish    = (r_state == kms_pkg::ST_FINISH) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kms_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kms_pkg::ST_LOAD: begin
                if (pop && i_q_entry.last) begin
                    n_state = kms_pkg::ST_SCAN;
                end
            end
            kms_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = kms_pkg::ST_FINISH;
                end
            end
            kms_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = kms_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = kms_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_count[IW-1:0]] <= '{usable: i_q_entry.usable, ratio: i_q_entry.ratio};
        end
        if (issue) begin
            r_rd_data <= r_mem[r_issue[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_peak    <= '0;
            r_dropped <= 1'b0;
        end else if (finish) begin
            r_count   <= '0;
            r_peak    <= '0;
            r_dropped <= 1'b0;
        end else if (store) begin
            r_count <= r_count + 1'b1;
            if ((r_count != '0) && (r_last_ratio > r_peak)) begin
                r_peak <= r_last_ratio;
            end
        end else if (pop) begin
            r_dropped <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_last_ratio <= i_q_entry.ratio;
        end
    end

    always_comb begin
        motion_t = r_prev_u && r_rd_data.usable && (r_prev_ratio >= i_cfg.motion_thr);
        cont     = r_prev_u && r_rd_data.usable && (r_prev_ratio <= i_cfg.stable_thr) &&
                   !motion_t;
        run_new  = cont ? (r_run_len + 1'b1) : LW'(1);
        qualify  = r_rd_data.usable && (run_new >= LW'(i_cfg.min_run));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_q_entry.last) begin
            r_issue      <= '0;
            r_prev_u     <= 1'b0;
            r_any_u      <= 1'b0;
            r_any_m      <= 1'b0;
            r_best_valid <= 1'b0;
            r_run_len    <= '0;
        end else begin
            if (issue) begin
                r_issue  <= r_issue + 1'b1;
                r_rd_idx <= r_issue[IW-1:0];
            end
            if (r_rd_valid) begin
                r_prev_u     <= r_rd_data.usable;
                r_prev_ratio <= r_rd_data.ratio;
                r_run_len    <= run_new;
                if (r_rd_data.usable) begin
                    if (!r_any_u) begin
                        r_first_u <= r_rd_idx;
                    end
                    r_last_u <= r_rd_idx;
                    r_any_u  <= 1'b1;
                end
                if (motion_t) begin
                    if (!r_any_m) begin
                        r_fm <= r_rd_idx - IW'(1);
                    end
                    r_any_m <= 1'b1;
                end
                if (qualify) begin
                    r_best_valid <= 1'b1;
                    r_best       <= r_rd_idx;
                end else if (motion_t) begin
                    r_best_valid <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        aft_sel = r_best_valid ? r_best : r_last_u;
        n_bef   = r_any_u ? r_first_u : '0;
        n_aft   = r_any_u ? r_last_u : IW'(r_count - 1'b1);
        if (r_any_m && (aft_sel > r_fm)) begin
            n_bef = r_fm;
            n_aft = aft_sel;
        end
        n_res.before_frame = kms_pkg::OUT_IDX_W'(n_bef);
        n_res.after_frame  = kms_pkg::OUT_IDX_W'(n_aft);
        n_res.peak_ratio   = r_peak;
        n_res.overflow     = r_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

endmodule

`default_nettype wire

FILE: sv/keyframe_motion_selector.sv
// ----------------------------------------------------------------------------
// keyframe_motion_selector
// Picks the frames before and after a motion event from frame summaries.
// ----------------------------------------------------------------------------
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+------------------------------------------
//  in       | i_in_valid / o_in_ready | frame_mean, frame_empty, change_to_next,
//           |                         | last_frame
//  out      | o_out_valid/i_out_ready | before_frame, after_frame, peak_ratio,
//           |                         | overflow
//  config   | APB psel/penable/pwrite | four registers at byte addresses 0,4,8,12
//
// Frames load at one item per cycle while the queue has room.
// The last frame starts a scan of the frame memory, one read per cycle, over the
// n stored frames; input stalls once the queue fills.
// A result waits in the output register while the next sequence loads.
// Reset restores the register defaults and clears the frame count, peak, overflow flag and valid flags.
`default_nettype none

module keyframe_motion_selector (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [kms_pkg::MEAN_W-1:0]       i_frame_mean,
    input  wire logic                             i_frame_empty,
    input  wire logic [kms_pkg::RATIO_W-1:0]      i_change_to_next,
    input  wire logic                             i_last_frame,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [kms_pkg::OUT_IDX_W-1:0]         o_before_frame,
    output logic [kms_pkg::OUT_IDX_W-1:0]         o_after_frame,
    output logic [kms_pkg::RATIO_W-1:0]           o_peak_ratio,
    output logic                                  o_overflow,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [kms_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [kms_pkg::PDATA_W-1:0]      pwdata,
    output logic [kms_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready
);

    logic [kms_pkg::MEAN_W-1:0]   r_dark_thr;
    logic [kms_pkg::RATIO_W-1:0]  r_motion_thr;
    logic [kms_pkg::RATIO_W-1:0]  r_stable_thr;
    logic [kms_pkg::MINRUN_W-1:0] r_min_run;

    kms_pkg::t_reg_idx  reg_idx;
    logic               cfg_write;
    kms_pkg::t_scan_cfg scan_cfg;

    logic               fq_valid;
    logic               fq_ready;
    kms_pkg::t_entry    fq_entry;
    logic               qb_valid;
    logic               qb_ready;
    kms_pkg::t_entry    qb_entry;
    kms_pkg::t_result   result;

    assign pready    = 1'b1;
    assign reg_idx   = kms_pkg::t_reg_idx'(paddr[kms_pkg::PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_thr   <= kms_pkg::DARK_RESET;
            r_motion_thr <= kms_pkg::MOTION_RESET;
            r_stable_thr <= kms_pkg::STABLE_RESET;
            r_min_run    <= kms_pkg::MINRUN_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                kms_pkg::REG_DARK:   r_dark_thr   <= pwdata[kms_pkg::MEAN_W-1:0];
                kms_pkg::REG_MOTION: r_motion_thr <= pwdata[kms_pkg::RATIO_W-1:0];
                kms_pkg::REG_STABLE: r_stable_thr <= pwdata[kms_pkg::RATIO_W-1:0];
                kms_pkg::REG_MINRUN: r_min_run    <= pwdata[kms_pkg::MINRUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            kms_pkg::REG_DARK:   prdata = kms_pkg::PDATA_W'(r_dark_thr);
            kms_pkg::REG_MOTION: prdata = kms_pkg::PDATA_W'(r_motion_thr);
            kms_pkg::REG_STABLE: prdata = kms_pkg::PDATA_W'(r_stable_thr);
            kms_pkg::REG_MINRUN: prdata = kms_pkg::PDATA_W'(r_min_run);
            default:             prdata = '0;
        endcase
    end

    assign scan_cfg.motion_thr = r_motion_thr;
    assign scan_cfg.stable_thr = r_stable_thr;
    assign scan_cfg.min_run    = r_min_run;

    kms_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_frame_mean     (i_frame_mean),
        .i_frame_empty    (i_frame_empty),
        .i_change_to_next (i_change_to_next),
        .i_last_frame     (i_last_frame),
        .i_dark_thr       (r_dark_thr),
        .o_q_valid        (fq_valid),
        .i_q_ready        (fq_ready),
        .o_q_entry        (fq_entry)
    );

    kms_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_data  (fq_entry),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_data   (qb_entry)
    );

    kms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (qb_valid),
        .o_q_ready   (qb_ready),
        .i_q_entry   (qb_entry),
        .i_cfg       (scan_cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_before_frame = result.before_frame;
    assign o_after_frame  = result.after_frame;
    assign o_peak_ratio   = result.peak_ratio;
    assign o_overflow     = result.overflow;

endmodule

`default_nettype wire

FILE: sv/kms_checker.sv
// ----------------------------------------------------------------------------
// kms_checker
// Port-level checks on the result channel of the keyframe motion selector.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kms_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [kms_pkg::OUT_IDX_W-1:0]    o_before_frame,
    input wire logic [kms_pkg::OUT_IDX_W-1:0]    o_after_frame,
    input wire logic [kms_pkg::RATIO_W-1:0]      o_peak_ratio,
    input wire logic                             o_overflow
);

    logic                                             stalled;
    logic                                             ordered;
    logic [2*kms_pkg::OUT_IDX_W+kms_pkg::RATIO_W:0]   held_result;

    assign stalled     = o_out_valid && !i_out_ready;
    assign ordered     = (o_before_frame <= o_after_frame);
    assign held_result = {o_before_frame, o_after_frame, o_peak_ratio, o_overflow};

    `KMS_ASSERT(a_out_hold, i_clk, i_rst_n, stalled |=> o_out_valid, "result dropped in stall")
    `KMS_ASSERT(a_hold_data, i_clk, i_rst_n, stalled |=> $stable(held_result), "payload changed")
    `KMS_ASSERT(a_order, i_clk, i_rst_n, o_out_valid |-> ordered, "frames out of order")
    `KMS_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid, "valid after reset")

endmodule

bind keyframe_motion_selector kms_checker u_kms_checker (.*);

`default_nettype wire

FILE: test/tb_keyframe_motion_selector.sv
// ----------------------------------------------------------------------------
// tb_keyframe_motion_selector
// Self-checking testbench for the keyframe motion selector. Frame summaries are
// sent in sequences. A behavioral predictor works out the before and after
// frames, the peak ratio and the overflow flag of every sequence, and each
// result is checked in order. Both channels idle at random, and the thresholds
// are swept through their extremes between sequences.
// ----------------------------------------------------------------------------
module tb_keyframe_motion_selector;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES = kms_pkg::MAX_FRAMES + 16;
    localparam int unsigned STALL_LIMIT   = 20000;
    localparam int unsigned REPORT_LIMIT  = 10;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic [kms_pkg::MEAN_W-1:0]        i_frame_mean = '0;
    logic                              i_frame_empty = 1'b0;
    logic [kms_pkg::RATIO_W-1:0]       i_change_to_next = '0;
    logic                              i_last_frame = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic [kms_pkg::OUT_IDX_W-1:0]     o_before_frame;
    logic [kms_pkg::OUT_IDX_W-1:0]     o_after_frame;
    logic [kms_pkg::RATIO_W-1:0]       o_peak_ratio;
    logic                              o_overflow;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [kms_pkg::PADDR_W-1:0]       paddr = '0;
    logic [kms_pkg::PDATA_W-1:0]       pwdata = '0;
    logic [kms_pkg::PDATA_W-1:0]       prdata;
    logic                              pready;

    keyframe_motion_selector u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_frame_mean     (i_frame_mean),
        .i_frame_empty    (i_frame_empty),
        .i_change_to_next (i_change_to_next),
        .i_last_frame     (i_last_frame),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_before_frame   (o_before_frame),
        .o_after_frame    (o_after_frame),
        .o_peak_ratio     (o_peak_ratio),
        .o_overflow       (o_overflow),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Threshold copies and the frames of the sequence being loaded.
    logic [kms_pkg::MEAN_W-1:0]   cfg_dark    = kms_pkg::DARK_RESET;
    logic [kms_pkg::RATIO_W-1:0]  cfg_motion  = kms_pkg::MOTION_RESET;
    logic [kms_pkg::RATIO_W-1:0]  cfg_stable  = kms_pkg::STABLE_RESET;
    logic [kms_pkg::MINRUN_W-1:0] cfg_min_run = kms_pkg::MINRUN_RESET;

    bit                           seq_usable [kms_pkg::MAX_FRAMES];
    logic [kms_pkg::RATIO_W-1:0]  seq_ratio [kms_pkg::MAX_FRAMES];
    int unsigned                  seq_len = 0;
    logic [kms_pkg::RATIO_W-1:0]  seq_peak = '0;
    bit                           seq_dropped = 1'b0;

    kms_pkg::t_result             selections_due [$];
    int unsigned                  error_count = 0;
    int unsigned                  idle_count = 0;
    int unsigned                  random_frames = 0;
    int unsigned                  random_sequences = 0;
    bit                           g_steady = 1'b0;

    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (g_steady) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic kms_pkg::t_result predict_selection();
        int unsigned n, i, first_u, last_u, first_m, last_m, f, run_end, best;
        int unsigned before_f, after_f;
        bit any_u, any_m;
        kms_pkg::t_result res;
        n = seq_len;
        first_u = 0;
        last_u = 0;
        first_m = 0;
        last_m = 0;
        any_u = 1'b0;
        any_m = 1'b0;
        for (i = 0; i < n; i++) begin
            if (seq_usable[i]) begin
                if (!any_u) begin
                    first_u = i;
                end
                last_u = i;
                any_u = 1'b1;
            end
        end
        before_f = any_u ? first_u : 0;
        after_f = any_u ? last_u : n - 1;
        if (n >= 2 && any_u) begin
            for (i = 0; i + 1 < n; i++) begin
                if (seq_usable[i] && seq_usable[i + 1] && seq_ratio[i] >= cfg_motion) begin
                    if (!any_m) begin
                        first_m = i;
                    end
                    last_m = i;
                    any_m = 1'b1;
                end
            end
            if (any_m) begin
                before_f = first_m;
                best = last_u;
                f = last_m + 1;
                while (f < n) begin
                    while (f < n && !seq_usable[f]) begin
                        f++;
                    end
                    if (f >= n) begin
                        break;
                    end
                    run_end = f;
                    while (run_end + 1 < n && seq_usable[run_end + 1] &&
                           seq_ratio[run_end] <= cfg_stable) begin
                        run_end++;
                    end
                    if (run_end - f + 1 >= cfg_min_run) begin
                        best = run_end;
                    end
                    f = run_end + 1;
                end
                after_f = best;
                if (after_f <= before_f) begin
                    before_f = first_u;
                    after_f = last_u;
                end
            end
        end
        res.before_frame = kms_pkg::OUT_IDX_W'(before_f);
        res.after_frame = kms_pkg::OUT_IDX_W'(after_f);
        res.peak_ratio = seq_peak;
        res.overflow = seq_dropped;
        return res;
    endfunction

    function automatic void absorb_frame(input logic [kms_pkg::MEAN_W-1:0] mean,
                                         input logic empty,
                                         input logic [kms_pkg::RATIO_W-1:0] ratio,
                                         input logic last);
        logic [kms_pkg::RATIO_W-1:0] clipped;
        clipped = (ratio > kms_pkg::RATIO_MAX) ? kms_pkg::RATIO_MAX : ratio;
        if (seq_len < kms_pkg::MAX_FRAMES) begin
            if (seq_len > 0 && seq_ratio[seq_len - 1] > seq_peak) begin
                seq_peak = seq_ratio[seq_len - 1];
            end
            seq_usable[seq_len] = !empty && mean >= cfg_dark;
            seq_ratio[seq_len] = clipped;
            seq_len++;
        end else begin
            seq_dropped = 1'b1;
        end
        if (last) begin
            selections_due.insert(selections_due.size(), predict_selection());
            seq_len = 0;
            seq_peak = '0;
            seq_dropped = 1'b0;
        end
    endfunction

    task automatic send_frame(input logic [kms_pkg::MEAN_W-1:0] mean, input logic empty,
                              input logic [kms_pkg::RATIO_W-1:0] ratio, input logic last);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_frame_mean <= mean;
        i_frame_empty <= empty;
        i_change_to_next <= ratio;
        i_last_frame <= last;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        absorb_frame(mean, empty, ratio, last);
    endtask

    task automatic send_random_frame(input logic last);
        logic [kms_pkg::MEAN_W-1:0] mean;
        logic [kms_pkg::RATIO_W-1:0] ratio;
        logic [kms_pkg::RATIO_W-1:0] stable_cap;
        logic [kms_pkg::RATIO_W-1:0] motion_cap;
        logic empty;
        int unsigned pick;
        stable_cap = (cfg_stable > kms_pkg::RATIO_MAX) ? kms_pkg::RATIO_MAX : cfg_stable;
        motion_cap = (cfg_motion > kms_pkg::RATIO_MAX) ? kms_pkg::RATIO_MAX : cfg_motion;
        pick = $urandom_range(99);
        if (pick < 75) begin
            mean = kms_pkg::MEAN_W'($urandom_range(16'hFFFF, cfg_dark));
        end else if (pick < 85) begin
            mean = (cfg_dark == 0) ? '0 : kms_pkg::MEAN_W'($urandom_range(cfg_dark - 1, 0));
        end else if (pick < 90) begin
            mean = cfg_dark;
        end else begin
            mean = kms_pkg::MEAN_W'($urandom);
        end
        empty = ($urandom_range(99) < 8);
        pick = $urandom_range(99);
        if (pick < 35) begin
            ratio = kms_pkg::RATIO_W'($urandom_range(stable_cap, 0));
        end else if (pick < 60) begin
            ratio = kms_pkg::RATIO_W'($urandom_range(kms_pkg::RATIO_MAX, motion_cap));
        end else if (pick < 65) begin
            ratio = cfg_motion;
        end else if (pick < 70) begin
            ratio = cfg_stable;
        end else if (pick < 80) begin
            ratio = kms_pkg::RATIO_W'($urandom);
        end else begin
            ratio = kms_pkg::RATIO_W'($urandom_range(kms_pkg::RATIO_MAX, 0));
        end
        send_frame(mean, empty, ratio, last);
    endtask

    task automatic send_random_sequence();
        int unsigned len, pick, k;
        pick = $urandom_range(99);
        if (pick < 25) begin
            len = $urandom_range(24, 9);
        end else begin
            len = $urandom_range(8, 1);
        end
        for (k = 0; k < len; k++) begin
            send_random_frame(k == len - 1);
        end
        random_frames += len;
        random_sequences++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (selections_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input kms_pkg::t_reg_idx idx,
                                  input logic [kms_pkg::PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            kms_pkg::REG_DARK:   cfg_dark = value[kms_pkg::MEAN_W-1:0];
            kms_pkg::REG_MOTION: cfg_motion = value[kms_pkg::RATIO_W-1:0];
            kms_pkg::REG_STABLE: cfg_stable = value[kms_pkg::RATIO_W-1:0];
            kms_pkg::REG_MINRUN: cfg_min_run = value[kms_pkg::MINRUN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_thresholds(input logic [kms_pkg::PDATA_W-1:0] dark,
                                      input logic [kms_pkg::PDATA_W-1:0] motion,
                                      input logic [kms_pkg::PDATA_W-1:0] stable,
                                      input logic [kms_pkg::PDATA_W-1:0] min_run);
        wait_idle();
        write_register(kms_pkg::REG_DARK, dark);
        write_register(kms_pkg::REG_MOTION, motion);
        write_register(kms_pkg::REG_STABLE, stable);
        write_register(kms_pkg::REG_MINRUN, min_run);
    endtask

    // Reset thresholds; mean and ratio extremes, saturation and the dark boundary.
    task automatic test_directed_defaults();
        send_frame(16'hFFFF, 1'b0, 17'd100, 1'b0);
        send_frame(16'd3000, 1'b0, 17'd65536, 1'b0);
        send_frame(16'd2560, 1'b0, 17'd0, 1'b0);
        send_frame(16'd4000, 1'b0, 17'd655, 1'b0);
        send_frame(16'd5000, 1'b0, 17'd656, 1'b0);
        send_frame(16'd6000, 1'b0, 17'd3277, 1'b0);
        send_frame(16'd6000, 1'b0, 17'd65537, 1'b0);
        send_frame(16'd2559, 1'b0, 17'h1FFFF, 1'b0);
        send_frame(16'd7000, 1'b0, 17'd3276, 1'b0);
        send_frame(16'd7000, 1'b0, 17'd0, 1'b0);
        send_frame(16'd7000, 1'b0, 17'h1FFFF, 1'b1);
    endtask

    // Single frames, sequences with no usable frame and sequences with no motion.
    task automatic test_sparse_sequences();
        g_steady = 1'b1;
        send_frame(16'd0, 1'b0, 17'd0, 1'b1);
        send_frame(16'hFFFF, 1'b0, 17'h1FFFF, 1'b1);
        send_frame(16'd2559, 1'b0, 17'd65536, 1'b0);
        send_frame(16'hFFFF, 1'b1, 17'd65536, 1'b0);
        send_frame(16'd0, 1'b1, 17'd0, 1'b1);
        send_frame(16'd3000, 1'b0, 17'd10, 1'b0);
        send_frame(16'd3000, 1'b0, 17'd20, 1'b0);
        send_frame(16'd3000, 1'b0, 17'd3276, 1'b1);
        g_steady = 1'b0;
    endtask

    // A sequence that fills the store and then has its last frames dropped.
    task automatic test_capacity();
        int unsigned k;
        for (k = 0; k < kms_pkg::MAX_FRAMES + 2; k++) begin
            send_random_frame(k == kms_pkg::MAX_FRAMES + 1);
        end
    endtask

    task automatic test_threshold_sweep();
        int unsigned phase, s;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: program_thresholds(32'd0, 32'd0, 32'd0, 32'd1);
                1: program_thresholds(32'hFFFF, 32'd65536, 32'd65536, 32'd256);
                2: program_thresholds(32'd2560, 32'h1FFFF, 32'h1FFFF, 32'd0);
                3: program_thresholds($urandom_range(16'hFFFF), $urandom_range(65536),
                                      $urandom_range(65536), 32'h1FF);
                default: program_thresholds(32'd1, 32'd65535, 32'd1, 32'd2);
            endcase
            for (s = 0; s < 2; s++) begin
                send_random_sequence();
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [kms_pkg::PDATA_W-1:0] motion;
        while (random_frames < 200 || random_sequences < 24) begin
            if (random_sequences % 12 == 0) begin
                motion = $urandom_range(65536, 200);
                program_thresholds(($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                                            : $urandom_range(4000),
                                   motion, $urandom_range(motion / 4), $urandom_range(6, 1));
                g_steady = ($urandom_range(3) == 0);
            end
            send_random_sequence();
        end
        g_steady = 1'b0;
    endtask

    initial begin
        int unsigned hold, stall;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            hold = $urandom_range(12, 1);
            i_out_ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            stall = idle_cycles();
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        kms_pkg::t_result due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (selections_due.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("unexpected result: before=%0d after=%0d peak=%0d overflow=%0d",
                             o_before_frame, o_after_frame, o_peak_ratio, o_overflow);
                end
            end else begin
                due = selections_due.pop_front();
                if (o_before_frame !== due.before_frame || o_after_frame !== due.after_frame ||
                    o_peak_ratio !== due.peak_ratio || o_overflow !== due.overflow) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("mismatch: expected before=%0d after=%0d peak=%0d overflow=%0d",
                                 due.before_frame, due.after_frame, due.peak_ratio,
                                 due.overflow);
                        $display("          actual   before=%0d after=%0d peak=%0d overflow=%0d",
                                 o_before_frame, o_after_frame, o_peak_ratio, o_overflow);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count + 1 >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_defaults();
        test_sparse_sequences();
        test_capacity();
        test_threshold_sweep();
        test_random_traffic();
        wait_idle();
        if (error_count == 0 && selections_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
